// ===== design/sws_pkg.sv =====
// package: constants, word types and sequence arithmetic of the stop-and-wait sender
`default_nettype none
package sws_pkg;

  localparam int SEQ_SPACE    = 30720;
  localparam int HEADER_BYTES = 15;
  localparam int MAX_CHUNK    = 1008;

  localparam int SEQ_W   = 15;
  localparam int BYTES_W = 10;
  localparam int PKT_W   = 11;
  localparam int TICK_W  = 16;
  localparam int RETRY_W = 4;
  localparam int PHASE_W = 3;
  localparam int CFG_W   = 16;
  localparam int CFG_IDX_W = 2;

  // event kinds
  localparam logic [1:0] KIND_TICK   = 2'd0;
  localparam logic [1:0] KIND_HEADER = 2'd1;
  localparam logic [1:0] KIND_CHUNK  = 2'd2;

  // phases
  localparam logic [PHASE_W-1:0] PH_WAIT_SYN   = 3'd0;
  localparam logic [PHASE_W-1:0] PH_WAIT_REQ   = 3'd1;
  localparam logic [PHASE_W-1:0] PH_NEED_CHUNK = 3'd2;
  localparam logic [PHASE_W-1:0] PH_WAIT_DACK  = 3'd3;
  localparam logic [PHASE_W-1:0] PH_WAIT_FIN   = 3'd4;
  localparam logic [PHASE_W-1:0] PH_DONE       = 3'd5;

  // held flag bits
  localparam logic [2:0] FL_SYN = 3'b001;
  localparam logic [2:0] FL_ACK = 3'b010;
  localparam logic [2:0] FL_FIN = 3'b100;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_INITIAL_SEQUENCE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_TICKS    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RETRY_LIMIT      = 2'd2;

  localparam logic [SEQ_W-1:0]   INITIAL_SEQUENCE_RESET = 15'd0;
  localparam logic [TICK_W-1:0]  TIMEOUT_TICKS_RESET    = 16'd500;
  localparam logic [RETRY_W-1:0] RETRY_LIMIT_RESET      = 4'd5;

  typedef struct packed {
    logic [1:0]         kind;
    logic [31:0]        rx_seq;
    logic [31:0]        rx_ack;
    logic [BYTES_W-1:0] rx_data_bytes;
    logic [BYTES_W-1:0] chunk_bytes;
    logic               chunk_final;
    logic               file_found;
  } in_item_t;

  typedef struct packed {
    logic               send_valid;
    logic [SEQ_W-1:0]   tx_seq;
    logic [SEQ_W-1:0]   tx_ack;
    logic               tx_syn;
    logic               tx_ack_flag;
    logic               tx_fin;
    logic [BYTES_W-1:0] tx_data_bytes;
    logic               retransmission;
    logic [PHASE_W-1:0] phase_out;
  } out_item_t;

  function automatic logic [PKT_W-1:0] pkt_size(input logic [BYTES_W-1:0] bytes);
    logic [PKT_W-1:0] size;
    size = PKT_W'(HEADER_BYTES) + {1'b0, bytes} + PKT_W'(bytes != '0);
    return size;
  endfunction

  // 32-bit value modulo 30720 = 15 * 2048: low 11 bits pass, the rest is reduced
  // modulo 15 by folding nibbles (16 is 1 modulo 15)
  function automatic logic [SEQ_W-1:0] seq_mod_wide(input logic [31:0] x);
    logic [20:0] q;
    logic [6:0]  s1;
    logic [4:0]  s2;
    logic [4:0]  s3;
    logic [3:0]  r;
    q  = x[31:11];
    s1 = 7'(q[3:0]) + 7'(q[7:4]) + 7'(q[11:8]) + 7'(q[15:12]) + 7'(q[19:16])
       + 7'(q[20]);
    s2 = 5'(s1[3:0]) + 5'(s1[6:4]);
    s3 = 5'(s2[3:0]) + 5'(s2[4]);
    r  = (s3 >= 5'd15) ? 4'(s3 - 5'd15) : s3[3:0];
    return {r, x[10:0]};
  endfunction

  // sum below twice the space, one compare and subtract
  function automatic logic [SEQ_W-1:0] seq_add_small(input logic [SEQ_W-1:0] a,
                                                     input logic [PKT_W-1:0] b);
    logic [SEQ_W:0] sum;
    sum = {1'b0, a} + (SEQ_W+1)'(b);
    if (sum >= (SEQ_W+1)'(SEQ_SPACE)) begin
      sum = sum - (SEQ_W+1)'(SEQ_SPACE);
    end
    return sum[SEQ_W-1:0];
  endfunction

endpackage
`default_nettype wire

// ===== design/sws_if.sv =====
// interfaces: event word channel and result word channel
`default_nettype none
interface sws_in_if;
  import sws_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface sws_out_if;
  import sws_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== design/stop_and_wait_file_sender.sv =====
// top level: stop-and-wait file sender, one event word in, one result word out
//
//  channel   | dir | handshake          | word
//  ----------+-----+--------------------+-----------------------------------
//  events    | in  | valid / ready      | kind, rx header, chunk info
//  results   | out | valid / ready      | tx header, retransmission, phase
//  cfg       | in  | cfg_we, no wait    | cfg_index, cfg_data
//
//  one event per cycle while results are accepted: an event word is registered,
//  then the phase logic and sequence adders turn it into one result word, which
//  is held in the output register. a stalled result holds in the output
//  register while one more event waits in the input register. synchronous reset
//  clears phase, timer, counters and both stage valids; no clearing pass.
`default_nettype none
module stop_and_wait_file_sender
  import sws_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  sws_in_if.sink                    events,
  sws_out_if.source                 results,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data
);

  // configuration
  logic [TICK_W-1:0]  timeout_ticks;
  logic [RETRY_W-1:0] retry_limit;

  // transfer state
  logic [PHASE_W-1:0] phase, phase_next;
  logic [SEQ_W-1:0]   next_sequence, next_sequence_next;
  logic [SEQ_W-1:0]   peer_ack_value, peer_ack_value_next;
  logic [SEQ_W-1:0]   held_seq, held_seq_next;
  logic [SEQ_W-1:0]   held_ack, held_ack_next;
  logic [2:0]         held_flags, held_flags_next;
  logic [BYTES_W-1:0] held_bytes, held_bytes_next;
  logic [TICK_W-1:0]  elapsed_ticks, elapsed_ticks_next;
  logic [RETRY_W-1:0] fin_retries, fin_retries_next;
  logic               final_sent, final_sent_next;

  // stages
  logic      ev_valid;
  in_item_t  ev;
  logic      res_valid;
  out_item_t res;
  out_item_t res_next;
  logic      fire;

  assign fire = ev_valid && (!res_valid || results.ready);
  assign events.ready = !ev_valid || fire;
  assign results.valid = res_valid;
  assign results.data = res;

  // per-event helpers
  logic [SEQ_W-1:0]   rx_peer;
  logic               ack_match;
  logic [TICK_W:0]    tick_count;
  logic               expired;
  logic [BYTES_W-1:0] chunk_sat;
  logic [RETRY_W-1:0] retries_inc;
  logic               send_new;
  logic               send_any;
  logic               retx;
  logic [2:0]         new_flags;
  logic [BYTES_W-1:0] new_bytes;

  always_comb begin
    rx_peer     = seq_mod_wide(ev.rx_seq + 32'(pkt_size(ev.rx_data_bytes)));
    ack_match   = (ev.rx_ack == 32'(next_sequence));
    tick_count  = {1'b0, elapsed_ticks} + 17'd1;
    expired     = (tick_count >= {1'b0, timeout_ticks});
    chunk_sat   = (ev.chunk_bytes > BYTES_W'(MAX_CHUNK)) ? BYTES_W'(MAX_CHUNK)
                                                         : ev.chunk_bytes;
    retries_inc = fin_retries + 4'd1;

    phase_next          = phase;
    next_sequence_next  = next_sequence;
    peer_ack_value_next = peer_ack_value;
    held_seq_next       = held_seq;
    held_ack_next       = held_ack;
    held_flags_next     = held_flags;
    held_bytes_next     = held_bytes;
    elapsed_ticks_next  = elapsed_ticks;
    fin_retries_next    = fin_retries;
    final_sent_next     = final_sent;
    send_new  = 1'b0;
    send_any  = 1'b0;
    retx      = 1'b0;
    new_flags = FL_ACK;
    new_bytes = '0;

    unique case (phase)
      PH_WAIT_SYN: begin
        if (ev.kind == KIND_HEADER) begin
          peer_ack_value_next = rx_peer;
          send_new   = 1'b1;
          new_flags  = FL_SYN | FL_ACK;
          phase_next = PH_WAIT_REQ;
        end
      end
      PH_WAIT_REQ, PH_WAIT_DACK: begin
        if (ev.kind == KIND_TICK) begin
          elapsed_ticks_next = expired ? '0 : tick_count[TICK_W-1:0];
          send_any = expired;
          retx     = expired;
        end else if (ev.kind == KIND_HEADER && ack_match) begin
          peer_ack_value_next = rx_peer;
          // request ack without a file, or ack of the last chunk: go to fin
          if ((phase == PH_WAIT_REQ) ? !ev.file_found : final_sent) begin
            send_new         = 1'b1;
            new_flags        = FL_ACK | FL_FIN;
            fin_retries_next = '0;
            phase_next       = PH_WAIT_FIN;
          end else begin
            phase_next = PH_NEED_CHUNK;
          end
        end
      end
      PH_NEED_CHUNK: begin
        if (ev.kind == KIND_CHUNK) begin
          send_new        = 1'b1;
          new_flags       = FL_ACK;
          new_bytes       = chunk_sat;
          final_sent_next = ev.chunk_final;
          phase_next      = PH_WAIT_DACK;
        end
      end
      PH_WAIT_FIN: begin
        if (ev.kind == KIND_TICK) begin
          elapsed_ticks_next = expired ? '0 : tick_count[TICK_W-1:0];
          if (expired) begin
            send_any         = 1'b1;
            retx             = 1'b1;
            fin_retries_next = retries_inc;
            if (retries_inc >= retry_limit) begin
              phase_next = PH_DONE;
            end
          end
        end else if (ev.kind == KIND_HEADER) begin
          phase_next = PH_DONE;
        end
      end
      default: begin
      end
    endcase

    if (send_new) begin
      send_any           = 1'b1;
      held_seq_next      = next_sequence;
      held_ack_next      = peer_ack_value_next;
      held_flags_next    = new_flags;
      held_bytes_next    = new_bytes;
      next_sequence_next = seq_add_small(next_sequence, pkt_size(new_bytes));
    end

    res_next = '0;
    if (send_any) begin
      res_next.send_valid     = 1'b1;
      res_next.tx_seq         = held_seq_next;
      res_next.tx_ack         = held_ack_next;
      res_next.tx_syn         = |(held_flags_next & FL_SYN);
      res_next.tx_ack_flag    = |(held_flags_next & FL_ACK);
      res_next.tx_fin         = |(held_flags_next & FL_FIN);
      res_next.tx_data_bytes  = held_bytes_next;
      res_next.retransmission = retx;
    end
    res_next.phase_out = phase_next;
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (events.valid && events.ready) begin
      ev <= events.data;
    end
    if (fire) begin
      res <= res_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ev_valid         <= 1'b0;
      res_valid        <= 1'b0;
      timeout_ticks    <= TIMEOUT_TICKS_RESET;
      retry_limit      <= RETRY_LIMIT_RESET;
      phase            <= PH_WAIT_SYN;
      next_sequence    <= INITIAL_SEQUENCE_RESET;
      peer_ack_value   <= '0;
      held_seq         <= '0;
      held_ack         <= '0;
      held_flags       <= '0;
      held_bytes       <= '0;
      elapsed_ticks    <= '0;
      fin_retries      <= '0;
      final_sent       <= 1'b0;
    end else begin
      if (events.valid && events.ready) begin
        ev_valid <= 1'b1;
      end else if (fire) begin
        ev_valid <= 1'b0;
      end

      if (fire) begin
        res_valid <= 1'b1;
      end else if (results.ready) begin
        res_valid <= 1'b0;
      end

      if (fire) begin
        phase          <= phase_next;
        next_sequence  <= next_sequence_next;
        peer_ack_value <= peer_ack_value_next;
        held_seq       <= held_seq_next;
        held_ack       <= held_ack_next;
        held_flags     <= held_flags_next;
        held_bytes     <= held_bytes_next;
        elapsed_ticks  <= elapsed_ticks_next;
        fin_retries    <= fin_retries_next;
        final_sent     <= final_sent_next;
      end

      if (cfg_we) begin
        unique case (cfg_index)
          REG_INITIAL_SEQUENCE: begin
            // still before the handshake: the new value starts the transfer
            if (phase == PH_WAIT_SYN) begin
              next_sequence <= cfg_data[SEQ_W-1:0];
            end
          end
          REG_TIMEOUT_TICKS: begin
            timeout_ticks <= cfg_data[TICK_W-1:0];
          end
          REG_RETRY_LIMIT: begin
            retry_limit <= cfg_data[RETRY_W-1:0];
          end
          default: begin
          end
        endcase
      end
    end
  end

endmodule
`default_nettype wire

// ===== tb/sv/sws_header_checker.sv =====
// checker: follows the sender state, works out each result word and compares it on arrival
`timescale 1ns / 100ps
module sws_header_checker
  import sws_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  sws_in_if                         events,
  sws_out_if                        results,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  output int                        mismatches,
  output int                        words_due,
  output logic [SEQ_W-1:0]          seq_now,
  output logic [PHASE_W-1:0]        phase_now
);

  logic [SEQ_W-1:0]   first_seq;
  logic [TICK_W-1:0]  timeout;
  logic [RETRY_W-1:0] retry_max;

  logic [PHASE_W-1:0] ph;
  logic [SEQ_W-1:0]   nseq;
  logic [SEQ_W-1:0]   peer_ack;
  logic [SEQ_W-1:0]   h_seq;
  logic [SEQ_W-1:0]   h_ack;
  logic [2:0]         h_flags;
  logic [BYTES_W-1:0] h_bytes;
  logic [TICK_W-1:0]  ticks;
  logic [RETRY_W-1:0] fin_tries;
  logic               last_chunk_out;

  out_item_t tx_headers_due[$];

  function automatic logic [PKT_W-1:0] packet_span(input logic [BYTES_W-1:0] n);
    return PKT_W'(HEADER_BYTES) + PKT_W'(n) + ((n != '0) ? PKT_W'(1) : PKT_W'(0));
  endfunction

  // the 32-bit sum wraps before the reduction into the sequence space
  function automatic logic [SEQ_W-1:0] seq_after(input logic [31:0] base,
                                                 input logic [PKT_W-1:0] span);
    logic [31:0] sum;
    sum = base + 32'(span);
    return SEQ_W'(sum % 32'(SEQ_SPACE));
  endfunction

  task automatic send_held(inout out_item_t w, input logic retx);
    w.send_valid     = 1'b1;
    w.tx_seq         = h_seq;
    w.tx_ack         = h_ack;
    w.tx_syn         = (h_flags & FL_SYN) != '0;
    w.tx_ack_flag    = (h_flags & FL_ACK) != '0;
    w.tx_fin         = (h_flags & FL_FIN) != '0;
    w.tx_data_bytes  = h_bytes;
    w.retransmission = retx;
  endtask

  task automatic send_fresh(inout out_item_t w, input logic [2:0] flags,
                            input logic [BYTES_W-1:0] n);
    h_seq   = nseq;
    h_ack   = peer_ack;
    h_flags = flags;
    h_bytes = n;
    nseq    = seq_after(32'(nseq), packet_span(n));
    send_held(w, 1'b0);
  endtask

  task automatic send_fin(inout out_item_t w);
    send_fresh(w, FL_ACK | FL_FIN, '0);
    fin_tries = '0;
    ph = PH_WAIT_FIN;
  endtask

  // timer reloads only on expiry
  task automatic count_tick(output logic expired);
    logic [TICK_W:0] e;
    e = {1'b0, ticks} + 1'b1;
    if (e >= {1'b0, timeout}) begin
      ticks = '0;
      expired = 1'b1;
    end else begin
      ticks = e[TICK_W-1:0];
      expired = 1'b0;
    end
  endtask

  task automatic compute_tx_header(input in_item_t ev, output out_item_t w);
    logic hit;
    logic [BYTES_W-1:0] n;
    w = '0;
    hit = 1'b0;
    case (ph)
      PH_WAIT_SYN: begin
        if (ev.kind == KIND_HEADER) begin
          peer_ack = seq_after(ev.rx_seq, packet_span(ev.rx_data_bytes));
          send_fresh(w, FL_SYN | FL_ACK, '0);
          ph = PH_WAIT_REQ;
        end
      end
      PH_WAIT_REQ, PH_WAIT_DACK: begin
        if (ev.kind == KIND_TICK) begin
          count_tick(hit);
          if (hit) send_held(w, 1'b1);
        end else if (ev.kind == KIND_HEADER && ev.rx_ack == 32'(nseq)) begin
          peer_ack = seq_after(ev.rx_seq, packet_span(ev.rx_data_bytes));
          if (ph == PH_WAIT_REQ) begin
            if (ev.file_found) ph = PH_NEED_CHUNK;
            else send_fin(w);
          end else if (last_chunk_out) begin
            send_fin(w);
          end else begin
            ph = PH_NEED_CHUNK;
          end
        end
      end
      PH_NEED_CHUNK: begin
        if (ev.kind == KIND_CHUNK) begin
          n = (ev.chunk_bytes > MAX_CHUNK) ? BYTES_W'(MAX_CHUNK) : ev.chunk_bytes;
          send_fresh(w, FL_ACK, n);
          last_chunk_out = ev.chunk_final;
          ph = PH_WAIT_DACK;
        end
      end
      PH_WAIT_FIN: begin
        if (ev.kind == KIND_TICK) begin
          count_tick(hit);
          if (hit) begin
            send_held(w, 1'b1);
            fin_tries = fin_tries + 1'b1;
            if (fin_tries >= retry_max) ph = PH_DONE;
          end
        end else if (ev.kind == KIND_HEADER) begin
          ph = PH_DONE;
        end
      end
      default: ;
    endcase
    w.phase_out = ph;
  endtask

  always @(posedge clk) begin : track
    out_item_t want;
    out_item_t got;
    if (rst) begin
      first_seq      = INITIAL_SEQUENCE_RESET;
      timeout        = TIMEOUT_TICKS_RESET;
      retry_max      = RETRY_LIMIT_RESET;
      ph             = PH_WAIT_SYN;
      nseq           = INITIAL_SEQUENCE_RESET;
      peer_ack       = '0;
      h_seq          = '0;
      h_ack          = '0;
      h_flags        = '0;
      h_bytes        = '0;
      ticks          = '0;
      fin_tries      = '0;
      last_chunk_out = 1'b0;
      mismatches     = 0;
      tx_headers_due.delete();
    end else begin
      // results first: a word leaving now belongs to an older event
      if (results.valid && results.ready) begin
        got = results.data;
        if (tx_headers_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result word: v%0b seq %0d ack %0d syn %0b ack %0b fin %0b",
                     got.send_valid, got.tx_seq, got.tx_ack, got.tx_syn,
                     got.tx_ack_flag, got.tx_fin);
        end else begin
          want = tx_headers_due.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch exp: v%0b seq %0d ack %0d syn %0b ack %0b fin %0b",
                       want.send_valid, want.tx_seq, want.tx_ack, want.tx_syn,
                       want.tx_ack_flag, want.tx_fin,
                       " bytes %0d rtx %0b phase %0d",
                       want.tx_data_bytes, want.retransmission, want.phase_out);
              $display("         act: v%0b seq %0d ack %0d syn %0b ack %0b fin %0b",
                       got.send_valid, got.tx_seq, got.tx_ack, got.tx_syn,
                       got.tx_ack_flag, got.tx_fin,
                       " bytes %0d rtx %0b phase %0d",
                       got.tx_data_bytes, got.retransmission, got.phase_out);
            end
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_INITIAL_SEQUENCE: begin
            first_seq = cfg_data[SEQ_W-1:0];
            if (ph == PH_WAIT_SYN) nseq = first_seq;
          end
          REG_TIMEOUT_TICKS: timeout = cfg_data[TICK_W-1:0];
          REG_RETRY_LIMIT:   retry_max = cfg_data[RETRY_W-1:0];
          default: ;
        endcase
      end
      if (events.valid && events.ready) begin
        compute_tx_header(events.data, want);
        tx_headers_due.push_back(want);
      end
    end
    words_due = tx_headers_due.size();
    seq_now   = nseq;
    phase_now = ph;
  end

endmodule

// ===== tb/sv/stop_and_wait_file_sender_tb.sv =====
// testbench top: drives one long transfer with noise and config changes, gives the verdict
`timescale 1ns / 100ps
module stop_and_wait_file_sender_tb;
  import sws_pkg::*;

  localparam int FILE_WORDS  = 1400;
  localparam int CYCLE_LIMIT = 600000;
  localparam int PAUSE_EVERY = 300;
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam logic [CFG_W-1:0] TIMEOUT_STEPS [6] = '{16'd0, 16'd65535, 16'd1, 16'd5,
                                                     16'd2, 16'd8};

  typedef enum {STALL_NONE, STALL_HALF, STALL_HEAVY, STALL_LONG} stall_mode_t;

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;
  int                   mismatches;
  int                   words_due;
  logic [SEQ_W-1:0]     seq_now;
  logic [PHASE_W-1:0]   phase_now;
  int                   cycles;

  sws_in_if  ev_ch ();
  sws_out_if res_ch ();

  stop_and_wait_file_sender u_top (
    .clk       (clk),
    .rst       (rst),
    .events    (ev_ch),
    .results   (res_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  sws_header_checker u_check (
    .clk        (clk),
    .rst        (rst),
    .events     (ev_ch),
    .results    (res_ch),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .mismatches (mismatches),
    .words_due  (words_due),
    .seq_now    (seq_now),
    .phase_now  (phase_now)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin : watchdog
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("FAIL");
    $finish;
  end

  // receiver stalls in segments of its own
  initial begin : result_stall
    stall_mode_t mode;
    int run;
    res_ch.ready = 1'b0;
    forever begin
      mode = stall_mode_t'($urandom_range(0, 3));
      run = (mode == STALL_LONG) ? $urandom_range(10, 30) : $urandom_range(5, 60);
      repeat (run) begin
        @(negedge clk);
        case (mode)
          STALL_NONE:  res_ch.ready = 1'b1;
          STALL_HALF:  res_ch.ready = ($urandom_range(0, 1) == 1);
          STALL_HEAVY: res_ch.ready = ($urandom_range(0, 3) == 0);
          default:     res_ch.ready = 1'b0;
        endcase
      end
    end
  end

  // entered and left at a falling edge
  task automatic push_word(input in_item_t w);
    ev_ch.valid = 1'b1;
    ev_ch.data  = w;
    do @(posedge clk); while (!ev_ch.ready);
    @(negedge clk);
  endtask

  task automatic hold_off(input int n);
    ev_ch.valid = 1'b0;
    repeat (n) @(negedge clk);
  endtask

  task automatic drain();
    ev_ch.valid = 1'b0;
    while (words_due != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  function automatic in_item_t random_word();
    in_item_t w;
    w.kind          = 2'($urandom_range(0, 3));
    w.rx_seq        = $urandom;
    w.rx_ack        = $urandom;
    w.rx_data_bytes = 10'($urandom);
    w.chunk_bytes   = 10'($urandom);
    w.chunk_final   = 1'($urandom);
    w.file_found    = 1'($urandom);
    return w;
  endfunction

  initial begin : stimulus
    in_item_t w;
    int counted;
    int pauses;
    int tail;
    int burst;
    int roll;
    int pick;
    logic end_by_header;
    logic final_queued;

    rst          = 1'b1;
    cfg_we       = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    ev_ch.valid  = 1'b0;
    ev_ch.data   = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // waiting for syn: tick, chunk and unknown kind are dropped
    w = random_word(); w.kind = KIND_TICK; push_word(w);
    w = random_word(); w.kind = KIND_CHUNK; w.chunk_bytes = '1; push_word(w);
    w = '1; push_word(w);
    drain();
    write_reg(REG_INITIAL_SEQUENCE, $urandom_range(0, 1) ? CFG_W'(SEQ_SPACE - 1) : '0);
    write_reg(REG_TIMEOUT_TICKS, 16'd2);
    write_reg(REG_RETRY_LIMIT, 16'd15);

    // syn whose sequence plus size wraps 32 bits
    w = random_word(); w.kind = KIND_HEADER; w.rx_seq = '1; w.rx_data_bytes = 10'd1009;
    push_word(w);
    w = '0; w.kind = KIND_TICK; push_word(w); push_word(w);
    // ack equal in the low bits only
    w = random_word(); w.kind = KIND_HEADER; w.rx_ack = {1'b1, 16'd0, seq_now};
    w.file_found = 1'b0; push_word(w);
    w = random_word(); w.kind = KIND_HEADER; w.rx_ack = 32'(seq_now) + 1; push_word(w);
    w = random_word(); w.kind = KIND_CHUNK; push_word(w);
    w = '0; w.kind = KIND_HEADER; w.rx_ack = 32'(seq_now); w.file_found = 1'b1;
    push_word(w);
    // chunk due: tick and header dropped
    w = random_word(); w.kind = KIND_TICK; push_word(w);
    w = random_word(); w.kind = KIND_HEADER; push_word(w);
    w = '1; w.kind = KIND_CHUNK; w.chunk_final = 1'b0; push_word(w);
    w = '0; w.kind = KIND_TICK; push_word(w); push_word(w);
    w = random_word(); w.kind = KIND_HEADER; w.rx_ack = 32'(seq_now); w.rx_seq = '1;
    w.rx_data_bytes = '1; push_word(w);
    w = '0; w.kind = KIND_CHUNK; push_word(w);
    w = random_word(); w.kind = KIND_HEADER; w.rx_ack = 32'(seq_now); push_word(w);
    w = random_word(); w.kind = KIND_CHUNK; w.chunk_bytes = BYTES_W'(MAX_CHUNK);
    w.chunk_final = 1'b0; push_word(w);
    w = random_word(); w.kind = KIND_HEADER; w.rx_ack = 32'(seq_now) + 32'h1_0000;
    push_word(w);
    drain();
    write_reg(REG_TIMEOUT_TICKS, 16'd3);

    end_by_header = 1'($urandom);
    counted = 0;
    pauses = 0;
    tail = 0;
    burst = 0;
    final_queued = 1'b0;
    while (tail < 8) begin
      if (burst == 0) begin
        burst = $urandom_range(1, 40);
        if ($urandom_range(0, 3) != 0) hold_off($urandom_range(1, 12));
      end
      burst--;
      if (!final_queued && counted >= (pauses + 1) * PAUSE_EVERY) begin
        pauses++;
        drain();
        write_reg(REG_TIMEOUT_TICKS, TIMEOUT_STEPS[pauses % 6]);
        write_reg(REG_RETRY_LIMIT, CFG_W'($urandom_range(1, 15)));
        write_reg(REG_INITIAL_SEQUENCE, CFG_W'($urandom_range(0, SEQ_SPACE - 1)));
      end
      w = random_word();
      roll = $urandom_range(0, 99);
      case (phase_now)
        PH_WAIT_REQ, PH_WAIT_DACK: begin
          if (roll < 30) begin
            w.kind = KIND_TICK;
            counted++;
          end else if (roll < 45) begin
            w.kind = KIND_HEADER;
            w.rx_ack = 32'(seq_now) ^ (32'd1 << $urandom_range(0, 31));
          end else if (roll >= 50) begin
            w.kind = KIND_HEADER;
            w.rx_ack = 32'(seq_now);
            w.file_found = 1'b1;
            counted++;
          end
        end
        PH_NEED_CHUNK: begin
          if (!final_queued && counted >= FILE_WORDS) begin
            // last chunk: settle the fin timing first
            drain();
            pick = $urandom_range(0, 3);
            write_reg(REG_RETRY_LIMIT, (pick == 0) ? CFG_W'(0) : (pick == 1) ? CFG_W'(1) :
                      (pick == 2) ? CFG_W'(15) : CFG_W'($urandom_range(2, 14)));
            write_reg(REG_TIMEOUT_TICKS, CFG_W'($urandom_range(0, 3)));
            w.kind = KIND_CHUNK;
            w.chunk_final = 1'b1;
            final_queued = 1'b1;
            counted++;
          end else if (roll < 80) begin
            w.kind = KIND_CHUNK;
            w.chunk_final = 1'b0;
            pick = $urandom_range(0, 9);
            if (pick == 0) w.chunk_bytes = '0;
            else if (pick == 1) w.chunk_bytes = BYTES_W'(MAX_CHUNK);
            else if (pick == 2) w.chunk_bytes = 10'($urandom_range(MAX_CHUNK + 1, 1023));
            else w.chunk_bytes = 10'($urandom_range(1, MAX_CHUNK));
            counted++;
          end else begin
            w.kind = (roll < 87) ? KIND_TICK : (roll < 94) ? KIND_HEADER : KIND_UNUSED;
          end
        end
        PH_WAIT_FIN: begin
          if (roll < 70) begin
            w.kind = KIND_TICK;
            counted++;
          end else if (end_by_header && roll < 80) begin
            w.kind = KIND_HEADER;
            counted++;
          end else begin
            w.kind = (roll % 2 == 0) ? KIND_CHUNK : KIND_UNUSED;
          end
        end
        PH_DONE: tail++;
        default: begin
          w.kind = KIND_HEADER;
          counted++;
        end
      endcase
      push_word(w);
    end

    drain();
    repeat (10) @(negedge clk);
    if (mismatches == 0 && words_due == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
